/* src/esd_pkg.sv */
// Shared types, constants and character helpers for the escape sequence decoder.
`default_nettype none
package esd_pkg;

  localparam int COUNT_W     = 16;
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [1:0] HEX_DIGITS     = 2'd2;
  localparam logic [1:0] OCT_DIGITS     = 2'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_BACKSLASH,
    MODE_HEX,
    MODE_OCT
  } mode_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               end_of_string;
    logic [COUNT_W-1:0] replace_count;
    logic               run_last;
  } result_t;

  typedef struct packed {
    logic [PUSH_W-1:0]               n;
    result_t [MAX_RESULTS-1:0]       res;
  } push_t;

  function automatic result_t make_result(input logic [7:0] b, input logic eos,
                                          input logic [COUNT_W-1:0] cnt);
    result_t r;
    r.out_byte      = b;
    r.end_of_string = eos;
    r.replace_count = cnt;
    r.run_last      = 1'b0;
    return r;
  endfunction

  // Returns zero when the character is not a named escape.
  function automatic logic [7:0] named_escape(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h22:   m = 8'h22;
      8'h27:   m = 8'h27;
      8'h5C:   m = 8'h5C;
      8'h3F:   m = 8'h3F;
      8'h61:   m = 8'h07;
      8'h62:   m = 8'h08;
      8'h66:   m = 8'h0C;
      8'h6E:   m = 8'h0A;
      8'h74:   m = 8'h09;
      8'h72:   m = 8'h0D;
      8'h76:   m = 8'h0B;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = {1'b1, 4'(c - 8'h37)};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* src/escape_sequence_decoder.sv */
// Top level of the escape sequence decoder.
//
// The input channel (in_valid, in_ready, in_byte, last) carries one string
// character per beat; last marks the final character of a string. The output
// channel (out_valid, out_ready and the result fields) carries zero to three
// result beats per input beat: cleaned bytes, then a summary beat with
// end_of_string set and the replacement count when the string closes.
// run_last flags the final result beat caused by one input beat.
// cfg_we and cfg_data write the escapes_enabled register, which applies to
// the next backslash seen outside an escape.
// A result beat enters the result buffer when its input beat is taken and is
// offered from there. Throughput is one input beat per cycle while each
// input yields at most one result and out_ready is high; the four-entry
// result buffer sets the pace otherwise, since in_ready is high only while
// at most one result waits. Reset clears the escape state, the count and the
// buffer, and sets escapes_enabled. When the receiver stalls, results stay
// in the buffer and input is taken until it holds two or more.
`default_nettype none
module escape_sequence_decoder (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        end_of_string,
  output logic [esd_pkg::COUNT_W-1:0] replace_count,
  output logic                        run_last,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_data
);
  import esd_pkg::*;

  push_t   push;
  result_t head;
  logic    accept;

  assign accept = in_valid && in_ready;

  esd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .last     (last),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push)
  );

  esd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .head      (head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready)
  );

  assign out_byte      = head.out_byte;
  assign end_of_string = head.end_of_string;
  assign replace_count = head.replace_count;
  assign run_last      = head.run_last;

endmodule
`default_nettype wire

/* src/esd_core.sv */
// Per-byte decode logic with escape state, count and configuration register.
`default_nettype none
module esd_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          last,
  input  wire logic          cfg_we,
  input  wire logic          cfg_data,
  output esd_pkg::push_t     push
);
  import esd_pkg::*;

  mode_t              mode, mode_next;
  logic [1:0]         digits_taken, digits_taken_next;
  logic [8:0]         digit_value, digit_value_next;
  logic               prefix_open, prefix_open_next;
  logic [COUNT_W-1:0] replacements, replacements_next;
  logic               escapes_enabled;

  always_comb begin
    logic [7:0] m;
    logic [4:0] hd;
    logic       dv;
    logic [3:0] d;
    logic [1:0] limit;
    mode_next         = mode;
    digits_taken_next = digits_taken;
    digit_value_next  = digit_value;
    prefix_open_next  = prefix_open;
    replacements_next = replacements;
    push              = '0;
    m                 = named_escape(in_byte);
    hd                = hex_digit(in_byte);
    dv                = 1'b0;
    d                 = 4'd0;
    limit             = OCT_DIGITS;

    case (mode)
      MODE_NORMAL: begin
        if (in_byte == CHAR_QUOTE) begin
          if (replacements != '1) replacements_next = replacements + 1'b1;
        end else if (in_byte == CHAR_BACKSLASH && escapes_enabled) begin
          mode_next = MODE_BACKSLASH;
        end else begin
          push.res[push.n] = make_result(in_byte, 1'b0, '0);
          push.n = push.n + 1'b1;
        end
      end
      MODE_BACKSLASH: begin
        if (m != 8'h00) begin
          push.res[push.n] = make_result(m, 1'b0, '0);
          push.n = push.n + 1'b1;
          if (replacements != '1) replacements_next = replacements + 1'b1;
          mode_next = MODE_NORMAL;
        end else if (in_byte == CHAR_X) begin
          if (replacements != '1) replacements_next = replacements + 1'b1;
          mode_next         = MODE_HEX;
          digits_taken_next = 2'd0;
          digit_value_next  = 9'd0;
          prefix_open_next  = 1'b1;
        end else if (in_byte inside {[8'h30:8'h39]}) begin
          if (replacements != '1) replacements_next = replacements + 1'b1;
          mode_next         = MODE_OCT;
          digits_taken_next = 2'd1;
          if (in_byte inside {[8'h30:8'h37]}) begin
            digit_value_next = {6'd0, in_byte[2:0]};
            prefix_open_next = 1'b1;
          end else begin
            digit_value_next = 9'd0;
            prefix_open_next = 1'b0;
          end
        end else begin
          push.res[push.n] = make_result(CHAR_BACKSLASH, 1'b0, '0);
          push.n = push.n + 1'b1;
          push.res[push.n] = make_result(in_byte, 1'b0, '0);
          push.n = push.n + 1'b1;
          mode_next = MODE_NORMAL;
        end
      end
      MODE_HEX, MODE_OCT: begin
        if (mode == MODE_HEX) begin
          dv    = hd[4];
          d     = hd[3:0];
          limit = HEX_DIGITS;
        end else begin
          dv    = in_byte inside {[8'h30:8'h37]};
          d     = {1'b0, in_byte[2:0]};
          limit = OCT_DIGITS;
        end
        if (prefix_open && dv) begin
          digit_value_next = (mode == MODE_HEX) ? {digit_value[4:0], d}
                                                : {digit_value[5:0], d[2:0]};
        end else begin
          prefix_open_next = 1'b0;
        end
        digits_taken_next = digits_taken + 2'd1;
        if (digits_taken_next >= limit) begin
          push.res[push.n] = make_result(digit_value_next[7:0], 1'b0, '0);
          push.n = push.n + 1'b1;
          mode_next         = MODE_NORMAL;
          digits_taken_next = 2'd0;
          digit_value_next  = 9'd0;
          prefix_open_next  = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    if (last) begin
      if (mode_next == MODE_BACKSLASH) begin
        push.res[push.n] = make_result(CHAR_BACKSLASH, 1'b0, '0);
        push.n = push.n + 1'b1;
      end else if (mode_next == MODE_HEX || mode_next == MODE_OCT) begin
        push.res[push.n] = make_result(digit_value_next[7:0], 1'b0, '0);
        push.n = push.n + 1'b1;
      end
      push.res[push.n] = make_result(8'h00, 1'b1, replacements_next);
      push.n = push.n + 1'b1;
      mode_next         = MODE_NORMAL;
      digits_taken_next = 2'd0;
      digit_value_next  = 9'd0;
      prefix_open_next  = 1'b0;
      replacements_next = '0;
    end

    if (push.n != '0) begin
      push.res[push.n - 1'b1].run_last = 1'b1;
    end
    if (!accept) begin
      push.n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      digits_taken    <= 2'd0;
      digit_value     <= 9'd0;
      prefix_open     <= 1'b0;
      replacements    <= '0;
      escapes_enabled <= 1'b1;
    end else begin
      if (accept) begin
        mode         <= mode_next;
        digits_taken <= digits_taken_next;
        digit_value  <= digit_value_next;
        prefix_open  <= prefix_open_next;
        replacements <= replacements_next;
      end
      if (cfg_we) begin
        escapes_enabled <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

/* src/esd_out_fifo.sv */
// Result buffer that takes up to three results a cycle and hands out one per beat.
`default_nettype none
module esd_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire esd_pkg::push_t   push,
  output esd_pkg::result_t      head,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  in_ready
);
  import esd_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [LEVEL_W-1:0] level, level_next;
  logic               pop;

  assign out_valid = level != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];
  assign in_ready  = level <= LEVEL_W'(FIFO_DEPTH - MAX_RESULTS);

  always_comb begin
    level_next = level + LEVEL_W'(push.n) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (PUSH_W'(i) < push.n) begin
        mem[wr_ptr + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      level  <= level_next;
    end
  end

endmodule
`default_nettype wire

/* src/esd_checker.sv */
// Port-level checks for the escape sequence decoder, bound to the top level.
`default_nettype none
module esd_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [7:0]             out_byte,
  input wire logic                   end_of_string,
  input wire logic [esd_pkg::COUNT_W-1:0] replace_count,
  input wire logic                   run_last
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(end_of_string) && $stable(replace_count) && $stable(run_last))
    else $error("stalled result beat changed");

  // The summary beat closes the results of its input and carries no byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> run_last && out_byte == 8'h00)
    else $error("summary beat malformed");

  // Data beats carry no count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_string |-> replace_count == '0)
    else $error("data beat carries a count");

  // Reset leaves an empty buffer that takes input.
  assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("buffer not empty after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .end_of_string (end_of_string),
  .replace_count (replace_count),
  .run_last      (run_last)
);
`default_nettype wire
